[rtl/eight_zone_midpoint_line_raster_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the eight-zone midpoint line rasterizer
// Shared wrappers that keep clocking, reset gating and reporting uniform.
// ----------------------------------------------------------------------------
`ifndef EIGHT_ZONE_MIDPOINT_LINE_RASTER_MACROS_SVH
`define EIGHT_ZONE_MIDPOINT_LINE_RASTER_MACROS_SVH

// Check a property on every rising edge, including edges inside reset.
`define EZML_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

// Check a property on every rising edge outside reset.
`define EZML_ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`endif

[rtl/ezml_pkg.sv]
// ----------------------------------------------------------------------------
// ezml_pkg
// Shared types and constants of the eight-zone midpoint line rasterizer.
// ----------------------------------------------------------------------------
package ezml_pkg;

  // Default coordinate width of the endpoints and pixels.
  localparam int COORD_BITS_DEF = 12;

  // Function codes of an input item.
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  // Octants of a line, numbered counterclockwise from the positive x axis.
  typedef enum logic [2:0] {
    OCT_0 = 3'd0,
    OCT_1 = 3'd1,
    OCT_2 = 3'd2,
    OCT_3 = 3'd3,
    OCT_4 = 3'd4,
    OCT_5 = 3'd5,
    OCT_6 = 3'd6,
    OCT_7 = 3'd7
  } octant_t;

endpackage

[rtl/eight_zone_midpoint_line_raster.sv]
// ----------------------------------------------------------------------------
// eight_zone_midpoint_line_raster
// Eight-octant midpoint line rasterizer producing at most one pixel per item.
// ----------------------------------------------------------------------------
// A start item (func = 0) carries two endpoints and yields the first pixel of
// the line at once; each advance item (func = 1) yields the next pixel, and
// the pixel on the second endpoint comes with last_pixel set. An advance with
// no line in progress yields an item with pixel_valid low and all other
// fields zero. A start abandons any line still in progress. Every input item
// gives exactly one result item, in the cycle after it is accepted, and
// the block takes one item per clock unless the result is stalled: the
// per-pixel step is a single error-term add plus a major-axis compare,
// done between the input ports and the result register. The result
// register lets a new item in during the same cycle that the waiting result
// is taken. in_stall is raised while the result is stalled and during reset.
// ----------------------------------------------------------------------------
module eight_zone_midpoint_line_raster #(
  parameter int COORD_BITS = ezml_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         pixel_valid,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [2:0]                   octant,
  output logic                         last_pixel
);
  import ezml_pkg::*;

  localparam int W = COORD_BITS + 1;   // folded coordinates
  localparam int E = COORD_BITS + 3;   // error term and increments

  // Line state
  logic                line_active, line_active_next;
  logic signed [W-1:0] walk_major, walk_major_next;
  logic signed [W-1:0] walk_minor, walk_minor_next;
  logic signed [W-1:0] major_end, major_end_next;
  logic signed [E-1:0] error_term, error_term_next;
  logic signed [E-1:0] east_increment, east_increment_next;
  logic signed [E-1:0] diagonal_increment, diagonal_increment_next;
  octant_t             line_octant, line_octant_next;

  // Result being formed this cycle
  logic                  res_valid;
  logic [COORD_BITS-1:0] res_x, res_y;
  logic [2:0]            res_oct;
  logic                  res_last;

  // Setup of a new line
  octant_t             su_oct;
  logic signed [W-1:0] su_major_start, su_minor_start, su_major_end;
  logic signed [E-1:0] su_error, su_east, su_diag;

  // Screen position of the walked point
  logic signed [W-1:0] scr_x, scr_y;

  logic take;

  ezml_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .oct         (su_oct),
    .major_start (su_major_start),
    .minor_start (su_minor_start),
    .major_end   (su_major_end),
    .error_init  (su_error),
    .east_inc    (su_east),
    .diag_inc    (su_diag)
  );

  // Hold input during reset and while the result register is full and not being drained.
  assign in_stall = rst | (out_valid & out_stall);
  assign take     = in_valid & ~in_stall;

  // Advance the line state by one item.
  always_comb begin
    line_active_next        = line_active;
    walk_major_next         = walk_major;
    walk_minor_next         = walk_minor;
    major_end_next          = major_end;
    error_term_next         = error_term;
    east_increment_next     = east_increment;
    diagonal_increment_next = diagonal_increment;
    line_octant_next        = line_octant;
    if (take) begin
      if (func == FUNC_START) begin
        walk_major_next         = su_major_start;
        walk_minor_next         = su_minor_start;
        major_end_next          = su_major_end;
        error_term_next         = su_error;
        east_increment_next     = su_east;
        diagonal_increment_next = su_diag;
        line_octant_next        = su_oct;
        line_active_next        = su_major_start < su_major_end;
      end else if (line_active) begin
        // Step east on a negative error, north-east otherwise.
        if (error_term[E-1]) begin
          error_term_next = error_term + east_increment;
        end else begin
          error_term_next = error_term + diagonal_increment;
          walk_minor_next = walk_minor + W'(1);
        end
        walk_major_next  = walk_major + W'(1);
        line_active_next = (walk_major + W'(1)) < major_end;
      end
    end
  end

  // Map the walked point back to screen coordinates.
  always_comb begin
    case (line_octant_next)
      OCT_0:   begin scr_x = walk_major_next;  scr_y = walk_minor_next;  end
      OCT_1:   begin scr_x = walk_minor_next;  scr_y = walk_major_next;  end
      OCT_2:   begin scr_x = -walk_minor_next; scr_y = walk_major_next;  end
      OCT_3:   begin scr_x = -walk_major_next; scr_y = walk_minor_next;  end
      OCT_4:   begin scr_x = -walk_major_next; scr_y = -walk_minor_next; end
      OCT_5:   begin scr_x = -walk_minor_next; scr_y = -walk_major_next; end
      OCT_6:   begin scr_x = walk_minor_next;  scr_y = -walk_major_next; end
      default: begin scr_x = walk_major_next;  scr_y = -walk_minor_next; end
    endcase
  end

  // Form the result item.
  always_comb begin
    res_valid = 1'b0;
    res_x     = '0;
    res_y     = '0;
    res_oct   = '0;
    res_last  = 1'b0;
    if (func == FUNC_START) begin
      // The first pixel is the first endpoint itself.
      res_valid = 1'b1;
      res_x     = start_x;
      res_y     = start_y;
      res_oct   = su_oct;
      res_last  = ~line_active_next;
    end else if (line_active) begin
      res_valid = 1'b1;
      res_x     = scr_x[COORD_BITS-1:0];
      res_y     = scr_y[COORD_BITS-1:0];
      res_oct   = line_octant_next;
      res_last  = ~line_active_next;
    end
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active        <= 1'b0;
      walk_major         <= '0;
      walk_minor         <= '0;
      major_end          <= '0;
      error_term         <= '0;
      east_increment     <= '0;
      diagonal_increment <= '0;
      line_octant        <= OCT_0;
    end else begin
      line_active        <= line_active_next;
      walk_major         <= walk_major_next;
      walk_minor         <= walk_minor_next;
      major_end          <= major_end_next;
      error_term         <= error_term_next;
      east_increment     <= east_increment_next;
      diagonal_increment <= diagonal_increment_next;
      line_octant        <= line_octant_next;
    end
  end

  // Result register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pixel_valid <= res_valid;
      pixel_x     <= res_x;
      pixel_y     <= res_y;
      octant      <= res_oct;
      last_pixel  <= res_last;
    end
  end

endmodule

[rtl/ezml_setup.sv]
// ----------------------------------------------------------------------------
// ezml_setup
// Classify a line's octant, fold it into octant 0 and set up the error terms.
// ----------------------------------------------------------------------------
module ezml_setup #(
  parameter int COORD_BITS = ezml_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output ezml_pkg::octant_t            oct,
  output logic signed [COORD_BITS:0]   major_start,
  output logic signed [COORD_BITS:0]   minor_start,
  output logic signed [COORD_BITS:0]   major_end,
  output logic signed [COORD_BITS+2:0] error_init,
  output logic signed [COORD_BITS+2:0] east_inc,
  output logic signed [COORD_BITS+2:0] diag_inc
);
  import ezml_pkg::*;

  localparam int W = COORD_BITS + 1;
  localparam int E = COORD_BITS + 3;

  logic signed [W-1:0] x0, y0, x1, y1;
  logic signed [W-1:0] dx, dy, adx, ady;
  logic signed [W-1:0] minor_end;
  logic signed [W-1:0] mdx, mdy;
  logic signed [E-1:0] e_mdx, e_mdy;
  logic                x_major;

  assign x0 = W'(start_x);
  assign y0 = W'(start_y);
  assign x1 = W'(end_x);
  assign y1 = W'(end_y);

  assign dx  = x1 - x0;
  assign dy  = y1 - y0;
  assign adx = dx[W-1] ? -dx : dx;
  assign ady = dy[W-1] ? -dy : dy;
  assign x_major = $unsigned(adx) >= $unsigned(ady);

  // Pick the octant from the signs of dx, dy and the dominant axis.
  always_comb begin
    case ({x_major, dx[W-1], dy[W-1]})
      3'b100:  oct = OCT_0;
      3'b110:  oct = OCT_3;
      3'b111:  oct = OCT_4;
      3'b101:  oct = OCT_7;
      3'b000:  oct = OCT_1;
      3'b010:  oct = OCT_2;
      3'b011:  oct = OCT_5;
      default: oct = OCT_6;
    endcase
  end

  // Mirror and swap the endpoints into octant 0.
  always_comb begin
    case (oct)
      OCT_0: begin
        major_start = x0;  minor_start = y0;  major_end = x1;  minor_end = y1;
      end
      OCT_1: begin
        major_start = y0;  minor_start = x0;  major_end = y1;  minor_end = x1;
      end
      OCT_2: begin
        major_start = y0;  minor_start = -x0; major_end = y1;  minor_end = -x1;
      end
      OCT_3: begin
        major_start = -x0; minor_start = y0;  major_end = -x1; minor_end = y1;
      end
      OCT_4: begin
        major_start = -x0; minor_start = -y0; major_end = -x1; minor_end = -y1;
      end
      OCT_5: begin
        major_start = -y0; minor_start = -x0; major_end = -y1; minor_end = -x1;
      end
      OCT_6: begin
        major_start = -y0; minor_start = x0;  major_end = -y1; minor_end = x1;
      end
      default: begin
        major_start = x0;  minor_start = -y0; major_end = x1;  minor_end = -y1;
      end
    endcase
  end

  assign mdx   = major_end - major_start;
  assign mdy   = minor_end - minor_start;
  assign e_mdx = E'(mdx);
  assign e_mdy = E'(mdy);

  assign east_inc   = e_mdy <<< 1;
  assign diag_inc   = (e_mdy - e_mdx) <<< 1;
  assign error_init = (e_mdy <<< 1) - e_mdx;

endmodule

[rtl/ezml_checker.sv]
// ----------------------------------------------------------------------------
// ezml_checker
// Port-level checks of the eight-zone midpoint line rasterizer.
// ----------------------------------------------------------------------------
`include "eight_zone_midpoint_line_raster_macros.svh"

module ezml_checker #(
  parameter int COORD_BITS = ezml_pkg::COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         func,
  input logic signed [COORD_BITS-1:0] start_x,
  input logic signed [COORD_BITS-1:0] start_y,
  input logic signed [COORD_BITS-1:0] end_x,
  input logic signed [COORD_BITS-1:0] end_y,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         pixel_valid,
  input logic signed [COORD_BITS-1:0] pixel_x,
  input logic signed [COORD_BITS-1:0] pixel_y,
  input logic [2:0]                   octant,
  input logic                         last_pixel
);
  import ezml_pkg::*;

  logic in_take;
  logic start_take;
  logic endpoints_match;

  assign in_take         = in_valid & ~in_stall;
  assign start_take      = in_take & (func == FUNC_START);
  assign endpoints_match = (start_x == end_x) & (start_y == end_y);

  // No result item right after reset.
  `EZML_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  // A start gives a valid pixel on the first endpoint in the cycle after it is accepted.
  `EZML_ASSERT_RUN(a_start_pixel, clk, rst,
    start_take |=> out_valid && pixel_valid && pixel_x == $past(start_x) &&
    pixel_y == $past(start_y))

  // A line with equal endpoints is a single last pixel in octant 0.
  `EZML_ASSERT_RUN(a_point_line, clk, rst,
    start_take && endpoints_match |=> last_pixel && octant == OCT_0)

  // An item without a pixel carries all-zero fields.
  `EZML_ASSERT_RUN(a_empty_zero, clk, rst,
    out_valid && !pixel_valid |->
    pixel_x == 0 && pixel_y == 0 && octant == 0 && !last_pixel)

  // A stalled result holds.
  `EZML_ASSERT_RUN(a_out_hold, clk, rst,
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y))

endmodule

bind eight_zone_midpoint_line_raster ezml_checker #(
  .COORD_BITS (COORD_BITS)
) u_ezml_checker (.*);
